>>> hdl/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared types and constants of the duration panel formatter: the elapsed
// time split, the decimal digit sets and the panel layout descriptors.
// ----------------------------------------------------------------------------
package dpf_pkg;

    localparam int DPF_PANEL_COUNT      = 3;
    localparam int DPF_PANEL_TEXT_CHARS = 5;
    localparam int DPF_CHAR_W           = 7;

    // panel shapes
    typedef enum logic [2:0] {
        SH_BLANK,
        SH_NUMBER,
        SH_LABEL,
        SH_COLON,
        SH_TENTHS
    } t_shape;

    // value shown in a panel slot
    typedef enum logic [2:0] {
        FD_NONE,
        FD_DAYS,
        FD_HOURS,
        FD_THOURS,
        FD_MINUTES,
        FD_SECONDS,
        FD_TENTHS
    } t_field;

    typedef struct packed {
        t_shape shape;
        t_field a;
        t_field b;
    } t_slot;

    typedef t_slot [2:0] t_layout;

    // four decimal digits, [3] is thousands
    typedef logic [3:0][3:0] t_dec;

    // elapsed time split into its parts (binary)
    typedef struct packed {
        logic [13:0] days;
        logic [13:0] thours;
        logic        big;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [3:0]  tenths;
    } t_split;

    // elapsed time parts as decimal digits
    typedef struct packed {
        t_dec       days;
        t_dec       thours;
        t_dec       hours;
        t_dec       minutes;
        t_dec       seconds;
        logic [3:0] tenths;
        logic       big;
    } t_vals;

    // one panel result towards the ports
    typedef struct packed {
        logic                       valid;
        logic [1:0]                 number;
        logic [4:0][DPF_CHAR_W-1:0] chars;
        logic                       last;
    } t_result;

endpackage

>>> hdl/dpf_time_split.sv
// ----------------------------------------------------------------------------
// dpf_time_split
// Pipeline that clamps the second count and splits it into days, hours,
// minutes and seconds by reciprocal multiplication with one correction step.
// ----------------------------------------------------------------------------
module dpf_time_split
    import dpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_total_seconds,
    input  logic [3:0]  i_tenths_digit,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output t_split      o_split
);

    localparam int NS = 7;

    logic [NS-1:0] r_v;
    logic [NS-1:0] mv;

    // stage 0: clamped input
    logic [30:0] r_s0;
    logic [3:0]  r_t0;
    // stage 1: day estimate
    logic [30:0] r_s1;
    logic [14:0] r_qd1;
    logic [3:0]  r_t1;
    // stage 2: days and remainder
    logic [14:0] r_days2;
    logic [16:0] r_rem2;
    logic [3:0]  r_t2;
    // stage 3: hour estimate
    logic [14:0] r_days3;
    logic [16:0] r_rem3;
    logic [4:0]  r_qh3;
    logic [3:0]  r_t3;
    // stage 4: hours and remainder
    logic [14:0] r_days4;
    logic [4:0]  r_hours4;
    logic [11:0] r_rem4;
    logic [3:0]  r_t4;
    // stage 5: minute estimate, total hours
    logic [13:0] r_days5;
    logic [13:0] r_thours5;
    logic        r_big5;
    logic [4:0]  r_hours5;
    logic [11:0] r_rem5;
    logic [5:0]  r_qm5;
    logic [3:0]  r_t5;
    // stage 6: result
    t_split      r_out;

    logic [45:0] p1;
    logic [17:0] m2;
    logic [17:0] rem18;
    logic        ge2;
    logic [22:0] p3;
    logic [16:0] m4;
    logic [12:0] r13;
    logic        ge4;
    logic [18:0] p5;
    logic [19:0] thours;
    logic [12:0] m6;
    logic [6:0]  r7;
    logic        ge6;

    // stage load enables ripple back from the consumer
    always_comb begin
        mv[NS-1] = !r_v[NS-1] || i_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            mv[i] = !r_v[i] || mv[i+1];
        end
    end

    assign o_ready = mv[0];
    assign o_valid = r_v[NS-1];
    assign o_split = r_out;

    always_comb begin
        p1     = {15'd0, r_s0} * 46'd24855;
        m2     = {3'd0, r_qd1} * 18'd86400;
        rem18  = r_s1[17:0] - m2;
        ge2    = rem18 >= 18'd86400;
        p3     = {6'd0, r_rem2} * 23'd36;
        m4     = {12'd0, r_qh3} * 17'd3600;
        r13    = r_rem3[12:0] - m4[12:0];
        ge4    = r13 >= 13'd3600;
        p5     = {7'd0, r_rem4} * 19'd68;
        thours = {5'd0, r_days4} * 20'd24 + {15'd0, r_hours4};
        m6     = {7'd0, r_qm5} * 13'd60;
        r7     = r_rem5[6:0] - m6[6:0];
        ge6    = r7 >= 7'd60;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (mv[i]) begin
                    r_v[i] <= (i == 0) ? i_valid : r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv[0]) begin
            r_s0 <= i_total_seconds[31] ? 31'd0 : i_total_seconds[30:0];
            r_t0 <= (i_tenths_digit > 4'd9) ? 4'd9 : i_tenths_digit;
        end
        if (mv[1]) begin
            r_s1  <= r_s0;
            r_qd1 <= p1[45:31];
            r_t1  <= r_t0;
        end
        if (mv[2]) begin
            r_days2 <= r_qd1 + {14'd0, ge2};
            r_rem2  <= ge2 ? 17'(rem18 - 18'd86400) : rem18[16:0];
            r_t2    <= r_t1;
        end
        if (mv[3]) begin
            r_days3 <= r_days2;
            r_rem3  <= r_rem2;
            r_qh3   <= p3[21:17];
            r_t3    <= r_t2;
        end
        if (mv[4]) begin
            r_days4  <= r_days3;
            r_hours4 <= r_qh3 + {4'd0, ge4};
            r_rem4   <= ge4 ? 12'(r13 - 13'd3600) : r13[11:0];
            r_t4     <= r_t3;
        end
        if (mv[5]) begin
            r_days5   <= (r_days4 > 15'd9999) ? 14'd9999 : r_days4[13:0];
            r_thours5 <= (thours > 20'd9999) ? 14'd9999 : thours[13:0];
            r_big5    <= thours > 20'd99;
            r_hours5  <= r_hours4;
            r_rem5    <= r_rem4;
            r_qm5     <= p5[17:12];
            r_t5      <= r_t4;
        end
        if (mv[6]) begin
            r_out.days    <= r_days5;
            r_out.thours  <= r_thours5;
            r_out.big     <= r_big5;
            r_out.hours   <= r_hours5;
            r_out.minutes <= r_qm5 + {5'd0, ge6};
            r_out.seconds <= ge6 ? 6'(r7 - 7'd60) : r7[5:0];
            r_out.tenths  <= r_t5;
        end
    end

endmodule

>>> hdl/dpf_digit_split.sv
// ----------------------------------------------------------------------------
// dpf_digit_split
// Pipeline that turns the split time parts into decimal digits: hundreds
// by reciprocal multiplication, then two-digit groups by a narrow divide.
// ----------------------------------------------------------------------------
module dpf_digit_split
    import dpf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_split i_split,
    output logic   o_ready,
    output logic   o_valid,
    input  logic   i_ready,
    output t_vals  o_vals
);

    localparam int NS = 3;

    logic [NS-1:0] r_v;
    logic [NS-1:0] mv;

    // stage 0: hundreds estimate, small values done
    t_split      r_sp0;
    logic [6:0]  r_dq0;
    logic [6:0]  r_tq0;
    t_dec        r_hours0;
    t_dec        r_min0;
    t_dec        r_sec0;
    // stage 1: hundreds and rest
    logic [6:0]  r_dhi1;
    logic [6:0]  r_dlo1;
    logic [6:0]  r_thi1;
    logic [6:0]  r_tlo1;
    t_dec        r_hours1;
    t_dec        r_min1;
    t_dec        r_sec1;
    logic [3:0]  r_ten1;
    logic        r_big1;
    // stage 2: result
    t_vals       r_out;

    logic [21:0] pd;
    logic [21:0] pt;
    logic [13:0] md;
    logic [13:0] mt;
    logic [7:0]  dlo;
    logic [7:0]  tlo;
    logic        dge;
    logic        tge;

    // two decimal digits of a value below 100
    function automatic logic [7:0] split2(input logic [6:0] x);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = {8'd0, x} * 15'd205;
        tens = p[14:11];
        ones = x - 7'({3'd0, tens} * 7'd10);
        return {tens, ones[3:0]};
    endfunction

    function automatic t_dec small_dec(input logic [6:0] x);
        return {8'd0, split2(x)};
    endfunction

    always_comb begin
        mv[NS-1] = !r_v[NS-1] || i_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            mv[i] = !r_v[i] || mv[i+1];
        end
    end

    assign o_ready = mv[0];
    assign o_valid = r_v[NS-1];
    assign o_vals  = r_out;

    always_comb begin
        pd  = {8'd0, i_split.days} * 22'd163;
        pt  = {8'd0, i_split.thours} * 22'd163;
        md  = {7'd0, r_dq0} * 14'd100;
        mt  = {7'd0, r_tq0} * 14'd100;
        dlo = r_sp0.days[7:0] - md[7:0];
        tlo = r_sp0.thours[7:0] - mt[7:0];
        dge = dlo >= 8'd100;
        tge = tlo >= 8'd100;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (mv[i]) begin
                    r_v[i] <= (i == 0) ? i_valid : r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv[0]) begin
            r_sp0    <= i_split;
            r_dq0    <= pd[20:14];
            r_tq0    <= pt[20:14];
            r_hours0 <= small_dec({2'd0, i_split.hours});
            r_min0   <= small_dec({1'd0, i_split.minutes});
            r_sec0   <= small_dec({1'd0, i_split.seconds});
        end
        if (mv[1]) begin
            r_dhi1   <= r_dq0 + {6'd0, dge};
            r_thi1   <= r_tq0 + {6'd0, tge};
            r_dlo1   <= dge ? 7'(dlo - 8'd100) : dlo[6:0];
            r_tlo1   <= tge ? 7'(tlo - 8'd100) : tlo[6:0];
            r_hours1 <= r_hours0;
            r_min1   <= r_min0;
            r_sec1   <= r_sec0;
            r_ten1   <= r_sp0.tenths;
            r_big1   <= r_sp0.big;
        end
        if (mv[2]) begin
            r_out.days    <= {split2(r_dhi1), split2(r_dlo1)};
            r_out.thours  <= {split2(r_thi1), split2(r_tlo1)};
            r_out.hours   <= r_hours1;
            r_out.minutes <= r_min1;
            r_out.seconds <= r_sec1;
            r_out.tenths  <= r_ten1;
            r_out.big     <= r_big1;
        end
    end

endmodule

>>> hdl/dpf_panel_emit.sv
// ----------------------------------------------------------------------------
// dpf_panel_emit
// Picks the panel layout, blanks leading zero panels, renders the panel
// text into a buffer and sends one panel per cycle.
// ----------------------------------------------------------------------------
module dpf_panel_emit
    import dpf_pkg::*;
#(
    parameter int PANEL_COUNT      = DPF_PANEL_COUNT,
    parameter int PANEL_TEXT_CHARS = DPF_PANEL_TEXT_CHARS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [3:0] i_format_select,
    input  logic       i_valid,
    input  t_vals      i_vals,
    output logic       o_ready,
    output t_result    o_result
);

    localparam int CW = (PANEL_COUNT > 1) ? $clog2(PANEL_COUNT) : 1;

    localparam logic [3:0] FMT_H_TENTHS       = 4'd12;
    localparam logic [3:0] FMT_H_SECONDS      = 4'd13;
    localparam logic [3:0] FMT_HCOLON_TENTHS  = 4'd14;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_ZERO  = 7'h30;

    typedef logic [4:0][DPF_CHAR_W-1:0] t_text;

    logic                  r_bv;
    logic [CW-1:0]         r_idx;
    logic [DPF_CHAR_W-1:0] r_buf [PANEL_COUNT][PANEL_TEXT_CHARS];

    t_layout lay;
    t_text   txt [3];
    logic    last_emit;
    logic    combined;

    function automatic t_slot mk(input t_shape s, input t_field a, input t_field b);
        return '{shape: s, a: a, b: b};
    endfunction

    function automatic t_layout layout_of(input logic [3:0] sel);
        t_slot dl;
        t_slot dn;
        t_slot c_hm;
        t_slot st;
        t_slot sn;
        dl   = mk(SH_LABEL, FD_DAYS, FD_NONE);
        dn   = mk(SH_NUMBER, FD_DAYS, FD_NONE);
        c_hm = mk(SH_COLON, FD_HOURS, FD_MINUTES);
        st   = mk(SH_TENTHS, FD_SECONDS, FD_TENTHS);
        sn   = mk(SH_NUMBER, FD_SECONDS, FD_NONE);
        case (sel)
            4'd0:  return {st, c_hm, dl};
            4'd1:  return {sn, c_hm, dl};
            4'd2:  return {mk(SH_COLON, FD_MINUTES, FD_SECONDS),
                           mk(SH_LABEL, FD_HOURS, FD_NONE), dl};
            4'd3:  return {mk(SH_LABEL, FD_MINUTES, FD_NONE),
                           mk(SH_LABEL, FD_HOURS, FD_NONE), dl};
            4'd4:  return {st, c_hm, dn};
            4'd5:  return {sn, c_hm, dn};
            4'd6:  return {mk(SH_COLON, FD_MINUTES, FD_SECONDS),
                           mk(SH_NUMBER, FD_HOURS, FD_NONE), dn};
            4'd7:  return {mk(SH_NUMBER, FD_MINUTES, FD_NONE),
                           mk(SH_NUMBER, FD_HOURS, FD_NONE), dn};
            4'd8:  return {st, mk(SH_LABEL, FD_MINUTES, FD_NONE),
                           mk(SH_LABEL, FD_HOURS, FD_NONE)};
            4'd9:  return {sn, mk(SH_LABEL, FD_MINUTES, FD_NONE),
                           mk(SH_LABEL, FD_HOURS, FD_NONE)};
            4'd10: return {st, mk(SH_LABEL, FD_MINUTES, FD_NONE),
                           mk(SH_LABEL, FD_THOURS, FD_NONE)};
            4'd11: return {sn, mk(SH_LABEL, FD_MINUTES, FD_NONE),
                           mk(SH_LABEL, FD_THOURS, FD_NONE)};
            4'd12: return {st, mk(SH_NUMBER, FD_MINUTES, FD_NONE),
                           mk(SH_NUMBER, FD_THOURS, FD_NONE)};
            4'd13: return {sn, mk(SH_NUMBER, FD_MINUTES, FD_NONE),
                           mk(SH_NUMBER, FD_THOURS, FD_NONE)};
            4'd14: return {st, mk(SH_COLON, FD_THOURS, FD_MINUTES),
                           mk(SH_BLANK, FD_NONE, FD_NONE)};
            default: return {sn, mk(SH_COLON, FD_THOURS, FD_MINUTES),
                             mk(SH_BLANK, FD_NONE, FD_NONE)};
        endcase
    endfunction

    function automatic t_dec field_dec(input t_field f, input t_vals v);
        case (f)
            FD_DAYS:    return v.days;
            FD_HOURS:   return v.hours;
            FD_THOURS:  return v.thours;
            FD_MINUTES: return v.minutes;
            FD_SECONDS: return v.seconds;
            FD_TENTHS:  return {12'd0, v.tenths};
            default:    return '0;
        endcase
    endfunction

    function automatic logic [6:0] unit_of(input t_field f);
        case (f)
            FD_DAYS:              return 7'h64;
            FD_HOURS, FD_THOURS:  return 7'h68;
            FD_MINUTES:           return 7'h6E;
            default:              return CH_SPACE;
        endcase
    endfunction

    function automatic logic [6:0] dig(input logic [3:0] d);
        return CH_ZERO + {3'd0, d};
    endfunction

    function automatic t_text render(input t_slot s, input t_vals v);
        t_dec  a;
        t_dec  b;
        logic  sh1;
        logic  sh2;
        logic  sh3;
        t_text t;
        a   = field_dec(s.a, v);
        b   = field_dec(s.b, v);
        sh3 = |a[3];
        sh2 = sh3 | (|a[2]);
        sh1 = sh2 | (|a[1]);
        t   = '0;
        case (s.shape)
            SH_NUMBER: begin
                t[0] = sh3 ? dig(a[3]) : CH_SPACE;
                t[1] = sh2 ? dig(a[2]) : CH_SPACE;
                t[2] = sh1 ? dig(a[1]) : CH_SPACE;
                t[3] = dig(a[0]);
            end
            SH_LABEL: begin
                if (sh2) begin
                    t[0] = sh3 ? dig(a[3]) : CH_SPACE;
                    t[1] = dig(a[2]);
                    t[2] = dig(a[1]);
                    t[3] = dig(a[0]);
                end else begin
                    t[0] = sh1 ? dig(a[1]) : CH_SPACE;
                    t[1] = dig(a[0]);
                    t[2] = CH_SPACE;
                    t[3] = unit_of(s.a);
                end
            end
            SH_COLON: begin
                t[0] = sh1 ? dig(a[1]) : CH_SPACE;
                t[1] = dig(a[0]);
                t[2] = CH_COLON;
                t[3] = dig(b[1]);
                t[4] = dig(b[0]);
            end
            SH_TENTHS: begin
                t[0] = sh1 ? dig(a[1]) : CH_SPACE;
                t[1] = dig(a[0]);
                t[2] = CH_COLON;
                t[3] = dig(b[0]);
            end
            default: begin
                t[0] = CH_SPACE;
                t[1] = CH_SPACE;
                t[2] = CH_SPACE;
                t[3] = CH_SPACE;
            end
        endcase
        return t;
    endfunction

    function automatic logic slot_zero(input t_slot s, input t_vals v);
        return (s.shape == SH_BLANK) ||
               ((field_dec(s.a, v) == '0) && (field_dec(s.b, v) == '0));
    endfunction

    // layout choice, fall back from combined hours, blank leading zeros
    always_comb begin
        lay      = layout_of(i_format_select);
        combined = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (lay[i].shape == SH_COLON && lay[i].a == FD_THOURS) begin
                combined = 1'b1;
            end
        end
        if (combined && i_vals.big) begin
            lay = layout_of((i_format_select == FMT_HCOLON_TENTHS) ?
                            FMT_H_TENTHS : FMT_H_SECONDS);
        end
        if (slot_zero(lay[0], i_vals)) begin
            lay[0] = mk(SH_BLANK, FD_NONE, FD_NONE);
            if (slot_zero(lay[1], i_vals)) begin
                lay[1] = mk(SH_BLANK, FD_NONE, FD_NONE);
            end
        end
        for (int i = 0; i < 3; i++) begin
            txt[i] = render(lay[i], i_vals);
        end
    end

    assign last_emit = r_bv && (r_idx == CW'(PANEL_COUNT - 1));
    assign o_ready   = !r_bv || last_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv  <= 1'b0;
            r_idx <= '0;
        end else if (o_ready && i_valid) begin
            r_bv  <= 1'b1;
            r_idx <= '0;
        end else if (r_bv) begin
            r_bv  <= !last_emit;
            r_idx <= last_emit ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int i = 0; i < PANEL_COUNT; i++) begin
                for (int k = 0; k < PANEL_TEXT_CHARS; k++) begin
                    r_buf[i][k] <= txt[i][k];
                end
            end
        end
    end

    assign o_result.valid  = r_bv;
    assign o_result.number = 2'(r_idx);
    assign o_result.last   = last_emit;

    for (genvar k = 0; k < 5; k++) begin : g_char
        if (k < PANEL_TEXT_CHARS) begin : g_used
            assign o_result.chars[k] = r_buf[r_idx][k];
        end else begin : g_zero
            assign o_result.chars[k] = '0;
        end
    end

endmodule

>>> hdl/duration_panel_formatter_unit.sv
// ----------------------------------------------------------------------------
// duration_panel_formatter_unit
// Formats an elapsed-second count as PANEL_COUNT ASCII panel texts in one of
// sixteen layouts chosen by the format_select register.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with i_start high and o_busy low. It
// passes the time split pipeline (seven stages), the digit pipeline (three
// stages) and the panel buffer, which then drives its first panel on the
// ports; its PANEL_COUNT panels follow in consecutive cycles, each
// marked by o_result_valid for exactly one cycle, panel 0 first, with
// o_last_panel on the final one. The receiver cannot stall: every strobed
// result must be taken in that cycle. The output port moves one panel a
// cycle; the panel buffer takes the next item while the last panel of the
// previous one is shown, and o_busy rises only when the pipeline has filled
// up behind the panel buffer. format_select (byte address 0) may be written
// only while no item is in flight; it is read back on prdata.
// ----------------------------------------------------------------------------
module duration_panel_formatter_unit
    import dpf_pkg::*;
#(
    parameter int PANEL_COUNT      = DPF_PANEL_COUNT,
    parameter int PANEL_TEXT_CHARS = DPF_PANEL_TEXT_CHARS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // item input
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_total_seconds,
    input  logic [3:0]  i_tenths_digit,
    // panel results
    output logic        o_result_valid,
    output logic [1:0]  o_panel_number,
    output logic [6:0]  o_char_first,
    output logic [6:0]  o_char_second,
    output logic [6:0]  o_char_third,
    output logic [6:0]  o_char_fourth,
    output logic [6:0]  o_char_fifth,
    output logic        o_last_panel
);

    localparam logic ADDR_FORMAT_SELECT = 1'b0;

    logic [3:0] r_format_select;

    logic    ts_ready;
    logic    ts_valid;
    t_split  ts_split;
    logic    ds_ready;
    logic    ds_valid;
    t_vals   ds_vals;
    logic    em_ready;
    t_result result;

    // register write at the access phase; the word index is address bit 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_select <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ADDR_FORMAT_SELECT) begin
            r_format_select <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_FORMAT_SELECT) ? {28'd0, r_format_select} : '0;

    // hold off new items only when the first stage cannot move
    assign o_busy = !ts_ready;

    dpf_time_split u_time_split (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_start),
        .i_total_seconds (i_total_seconds),
        .i_tenths_digit  (i_tenths_digit),
        .o_ready         (ts_ready),
        .o_valid         (ts_valid),
        .i_ready         (ds_ready),
        .o_split         (ts_split)
    );

    dpf_digit_split u_digit_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ts_valid),
        .i_split (ts_split),
        .o_ready (ds_ready),
        .o_valid (ds_valid),
        .i_ready (em_ready),
        .o_vals  (ds_vals)
    );

    dpf_panel_emit #(
        .PANEL_COUNT      (PANEL_COUNT),
        .PANEL_TEXT_CHARS (PANEL_TEXT_CHARS)
    ) u_panel_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_format_select (r_format_select),
        .i_valid         (ds_valid),
        .i_vals          (ds_vals),
        .o_ready         (em_ready),
        .o_result        (result)
    );

    // drive the result ports straight from the panel buffer
    assign o_result_valid = result.valid;
    assign o_panel_number = result.number;
    assign o_char_first   = result.chars[0];
    assign o_char_second  = result.chars[1];
    assign o_char_third   = result.chars[2];
    assign o_char_fourth  = result.chars[3];
    assign o_char_fifth   = result.chars[4];
    assign o_last_panel   = result.last;

endmodule
